// File: hw/rtl/ssc_pkg.sv
// shared types and constants of the sweep scan track controller
package ssc_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;

  // register indexes on the configuration channel
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_VALID  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCAN_MAX   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOST_MAX   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_RANGE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SWEEP_STEP = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_STEPS_DEG  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER     = 3'd6;

  // register reset values
  localparam logic [8:0]  MIN_VALID_RST  = 9'd2;
  localparam logic [8:0]  SCAN_MAX_RST   = 9'd300;
  localparam logic [8:0]  LOST_MAX_RST   = 9'd400;
  localparam logic [7:0]  HALF_RANGE_RST = 8'd90;
  localparam logic [6:0]  SWEEP_STEP_RST = 7'd5;
  localparam logic [4:0]  STEPS_DEG_RST  = 5'd5;
  localparam logic [11:0] CENTER_RST     = 12'd1024;

  localparam logic [7:0] HALF_RANGE_MAX = 8'd180;
  localparam logic [4:0] STEPS_DEG_MAX  = 5'd16;
  localparam logic [8:0] NEAREST_RST    = 9'd500;

  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_READING = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_FOUND   = 2'd1,
    EV_RESTART = 2'd2,
    EV_LOST    = 2'd3
  } event_t;

  // effective register values, clamps already applied
  typedef struct packed {
    logic [8:0]  min_valid_cm;
    logic [8:0]  scan_max_cm;
    logic [8:0]  lost_max_cm;
    logic [7:0]  half_deg;
    logic [6:0]  step_deg;
    logic [4:0]  steps_per_deg;
    logic [11:0] center;
  } cfg_t;

  typedef struct packed {
    logic signed [14:0] move_steps;
    logic               tracking;
    event_t             event_res;
    logic               target_found;
    logic signed [8:0]  target_angle;
    logic [8:0]         best_cm;
  } res_t;

endpackage

// File: hw/rtl/ssc_cfg_regs.sv
// configuration registers with range clamping
module ssc_cfg_regs
  import ssc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  output cfg_t                   cfg
);

  logic [8:0]  min_valid_r, scan_max_r, lost_max_r;
  logic [7:0]  half_range_r;
  logic [6:0]  sweep_step_r;
  logic [4:0]  steps_deg_r;
  logic [11:0] center_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_valid_r  <= MIN_VALID_RST;
      scan_max_r   <= SCAN_MAX_RST;
      lost_max_r   <= LOST_MAX_RST;
      half_range_r <= HALF_RANGE_RST;
      sweep_step_r <= SWEEP_STEP_RST;
      steps_deg_r  <= STEPS_DEG_RST;
      center_r     <= CENTER_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MIN_VALID:  min_valid_r  <= wr_data[8:0];
        REG_SCAN_MAX:   scan_max_r   <= wr_data[8:0];
        REG_LOST_MAX:   lost_max_r   <= wr_data[8:0];
        REG_HALF_RANGE: half_range_r <= wr_data[7:0];
        REG_SWEEP_STEP: sweep_step_r <= wr_data[6:0];
        REG_STEPS_DEG:  steps_deg_r  <= wr_data[4:0];
        REG_CENTER:     center_r     <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.min_valid_cm  = min_valid_r;
    cfg.scan_max_cm   = scan_max_r;
    cfg.lost_max_cm   = lost_max_r;
    cfg.half_deg      = (half_range_r > HALF_RANGE_MAX) ? HALF_RANGE_MAX : half_range_r;
    // a zero step would stall the sweep
    cfg.step_deg      = (sweep_step_r == 7'd0) ? 7'd1 : sweep_step_r;
    cfg.steps_per_deg = (steps_deg_r > STEPS_DEG_MAX) ? STEPS_DEG_MAX : steps_deg_r;
    cfg.center        = center_r;
  end

endmodule

// File: hw/rtl/ssc_core.sv
// sweep and tracking state with the per-item decision logic
module ssc_core
  import ssc_pkg::*;
#(
  parameter int DISTANCE_FRACTION_BITS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic        kind,
  input  logic [12:0] distance_q4,
  input  cfg_t        cfg,
  output res_t        res
);

  localparam int CW = (9 + DISTANCE_FRACTION_BITS > 13) ? 9 + DISTANCE_FRACTION_BITS : 13;

  logic               running_r, running_nxt;
  logic               tracking_r, tracking_nxt;
  logic               have_target_r, have_target_nxt;
  logic signed [8:0]  sweep_angle_r, sweep_angle_nxt;
  logic signed [13:0] motor_pos_r, motor_pos_nxt;
  logic [8:0]         nearest_cm_r, nearest_cm_nxt;
  logic signed [8:0]  nearest_angle_r, nearest_angle_nxt;

  logic [CW-1:0]      dist_w, lo_w, scan_w, lost_w, near_w;
  logic signed [9:0]  next_angle;
  logic signed [8:0]  neg_half;
  logic signed [8:0]  move_angle;
  logic               do_move, begin_sw, hit;
  event_t             ev;
  logic signed [14:0] product, target, move;

  assign dist_w = CW'(distance_q4);
  assign lo_w   = CW'(cfg.min_valid_cm) << DISTANCE_FRACTION_BITS;
  assign scan_w = CW'(cfg.scan_max_cm) << DISTANCE_FRACTION_BITS;
  assign lost_w = CW'(cfg.lost_max_cm) << DISTANCE_FRACTION_BITS;
  assign near_w = CW'(nearest_cm_r) << DISTANCE_FRACTION_BITS;

  assign hit        = (dist_w > lo_w) && (dist_w < scan_w) && (dist_w < near_w);
  assign next_angle = $signed({sweep_angle_r[8], sweep_angle_r}) + $signed({3'b000, cfg.step_deg});
  assign neg_half   = -$signed({1'b0, cfg.half_deg});

  always_comb begin
    running_nxt       = running_r;
    tracking_nxt      = tracking_r;
    have_target_nxt   = have_target_r;
    sweep_angle_nxt   = sweep_angle_r;
    nearest_cm_nxt    = nearest_cm_r;
    nearest_angle_nxt = nearest_angle_r;
    move_angle        = '0;
    do_move           = 1'b0;
    begin_sw          = 1'b0;
    ev                = EV_NONE;

    if (kind == KIND_START) begin
      begin_sw = 1'b1;
    end else if (running_r && tracking_r) begin
      if ((dist_w > lost_w) || (dist_w < lo_w)) begin
        begin_sw = 1'b1;
        ev       = EV_LOST;
      end else begin
        do_move    = 1'b1;
        move_angle = nearest_angle_r;
      end
    end else if (running_r) begin
      if (hit) begin
        nearest_cm_nxt    = 9'(distance_q4 >> DISTANCE_FRACTION_BITS);
        nearest_angle_nxt = sweep_angle_r;
        have_target_nxt   = 1'b1;
      end
      if (next_angle <= $signed({2'b00, cfg.half_deg})) begin
        sweep_angle_nxt = 9'(next_angle);
        move_angle      = 9'(next_angle);
        do_move         = 1'b1;
      end else if (have_target_nxt) begin
        tracking_nxt = 1'b1;
        move_angle   = nearest_angle_nxt;
        do_move      = 1'b1;
        ev           = EV_FOUND;
      end else begin
        begin_sw = 1'b1;
        ev       = EV_RESTART;
      end
    end

    if (begin_sw) begin
      running_nxt       = 1'b1;
      tracking_nxt      = 1'b0;
      have_target_nxt   = 1'b0;
      nearest_cm_nxt    = NEAREST_RST;
      nearest_angle_nxt = '0;
      sweep_angle_nxt   = neg_half;
      move_angle        = neg_half;
      do_move           = 1'b1;
    end
  end

  // absolute target position and relative move from the current one
  assign product       = 15'(move_angle * $signed({1'b0, cfg.steps_per_deg}));
  assign target        = $signed({3'b000, cfg.center}) + product;
  assign move          = do_move ? (target - $signed({motor_pos_r[13], motor_pos_r})) : '0;
  assign motor_pos_nxt = do_move ? 14'(target) : motor_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r       <= 1'b0;
      tracking_r      <= 1'b0;
      have_target_r   <= 1'b0;
      sweep_angle_r   <= '0;
      motor_pos_r     <= '0;
      nearest_cm_r    <= NEAREST_RST;
      nearest_angle_r <= '0;
    end else if (fire) begin
      running_r       <= running_nxt;
      tracking_r      <= tracking_nxt;
      have_target_r   <= have_target_nxt;
      sweep_angle_r   <= sweep_angle_nxt;
      motor_pos_r     <= motor_pos_nxt;
      nearest_cm_r    <= nearest_cm_nxt;
      nearest_angle_r <= nearest_angle_nxt;
    end
  end

  always_comb begin
    res.move_steps   = move;
    res.tracking     = tracking_nxt;
    res.event_res    = ev;
    res.target_found = have_target_nxt;
    res.target_angle = have_target_nxt ? nearest_angle_nxt : '0;
    res.best_cm      = have_target_nxt ? nearest_cm_nxt : '0;
  end

  // tracking only ever holds a target
  a_track_has_target: assert property (@(posedge clk) disable iff (!rst_n)
    tracking_r |-> (have_target_r && running_r))
    else $error("tracking without a held target");

  a_found_enters_track: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && ev == EV_FOUND) |=> tracking_r)
    else $error("found event did not enter tracking");

  a_lost_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (ev == EV_LOST || ev == EV_RESTART)) |=>
      (!tracking_r && !have_target_r && sweep_angle_r == $past(neg_half)))
    else $error("lost or empty sweep did not restart at minus half range");

endmodule

// File: hw/rtl/sweep_scan_track_controller.sv
// top level: input register, decision core, result register and handshakes
// each item is registered in the input register, then in the result register
// throughput: one item per cycle unless the result side stalls; a stalled result
// holds one further item in the input register
// reset: synchronous rst_n clears sweep state and loads register defaults
// cfg_ready is always high; a write takes effect on the next cycle
module sweep_scan_track_controller
  import ssc_pkg::*;
#(
  parameter int DISTANCE_FRACTION_BITS = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [15:0]            in_tdata,   // distance_q4 [12:0], zero [15:13]
  input  logic                   in_tuser,   // kind [0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // move_steps [14:0], tracking [15], event_res [17:16], target_found [18],
  // target_angle [27:19], best_cm [36:28], zero [39:37]
  output logic [39:0]            out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t        cfg;
  res_t        res;
  logic        in_fire, advance;
  logic        in_valid_r;
  logic        kind_r;
  logic [12:0] dist_r;
  logic        out_valid_r;
  res_t        out_r;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid && in_tready;
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  ssc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ssc_core #(
    .DISTANCE_FRACTION_BITS (DISTANCE_FRACTION_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (advance),
    .kind        (kind_r),
    .distance_q4 (dist_r),
    .cfg         (cfg),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_fire || (in_valid_r && !advance);
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= in_tuser;
      dist_r <= in_tdata[12:0];
    end
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r.best_cm, out_r.target_angle, out_r.target_found,
                       out_r.event_res, out_r.tracking, out_r.move_steps};

  // a held item is not dropped while the result register is stalled
  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_tready) |=> (in_valid_r && $stable(dist_r)))
    else $error("input item lost during output stall");

  // a new result only appears when an item was taken from the input register
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || out_tready) && !in_valid_r |=> !out_valid_r)
    else $error("result produced without a pending item");

  // a waiting result transaction stays put until taken
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_r)))
    else $error("result changed while waiting");

endmodule

// File: bench/sweep_scan_track_controller_tb.sv
// self-checking testbench of the sweep scan track controller
`timescale 1ns / 100ps

module sweep_scan_track_controller_tb;
  import ssc_pkg::*;

  localparam int FRAC_BITS   = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [15:0]            in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [39:0]            out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  always #6 clk = ~clk;

  sweep_scan_track_controller #(
    .DISTANCE_FRACTION_BITS(FRAC_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register copies, as written
  int reg_min_valid = MIN_VALID_RST;
  int reg_scan_max  = SCAN_MAX_RST;
  int reg_lost_max  = LOST_MAX_RST;
  int reg_half      = HALF_RANGE_RST;
  int reg_step      = SWEEP_STEP_RST;
  int reg_spd       = STEPS_DEG_RST;
  int reg_center    = CENTER_RST;

  // controller state as predicted
  bit     sweeping    = 1'b0;
  bit     locked      = 1'b0;
  bit     target_held = 1'b0;
  int     sweep_pos   = 0;
  int     motor_pos   = 0;
  int     near_cm     = NEAREST_RST;
  int     near_angle  = 0;
  event_t last_evt    = EV_NONE;

  res_t expected_reports[$];
  res_t want_rpt;

  int fail_count    = 0;
  int cycle_count   = 0;
  int hit_pct       = 30;
  bit quiet_stretch = 1'b0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;

  function automatic int eff_half();
    return (reg_half > HALF_RANGE_MAX) ? int'(HALF_RANGE_MAX) : reg_half;
  endfunction

  function automatic int eff_step();
    return (reg_step == 0) ? 1 : reg_step;
  endfunction

  function automatic int eff_spd();
    return (reg_spd > STEPS_DEG_MAX) ? int'(STEPS_DEG_MAX) : reg_spd;
  endfunction

  // relative move to an absolute angle, motor position follows
  function automatic int steer_to(input int angle);
    int target;
    int mv;
    target = reg_center + angle * eff_spd();
    mv = target - motor_pos;
    motor_pos = target;
    return mv;
  endfunction

  function automatic int restart_sweep();
    sweeping = 1'b1;
    locked = 1'b0;
    target_held = 1'b0;
    near_cm = NEAREST_RST;
    near_angle = 0;
    sweep_pos = -eff_half();
    return steer_to(sweep_pos);
  endfunction

  function automatic void predict_motion(input logic kind, input int reading);
    int   lo;
    int   mv;
    int   nxt;
    res_t r;
    lo = reg_min_valid << FRAC_BITS;
    mv = 0;
    last_evt = EV_NONE;
    if (kind == KIND_START) begin
      mv = restart_sweep();
    end else if (sweeping && locked) begin
      if (reading > (reg_lost_max << FRAC_BITS) || reading < lo) begin
        mv = restart_sweep();
        last_evt = EV_LOST;
      end else begin
        mv = steer_to(near_angle);
      end
    end else if (sweeping) begin
      if (reading > lo && reading < (reg_scan_max << FRAC_BITS) &&
          reading < (near_cm << FRAC_BITS)) begin
        near_cm = reading >> FRAC_BITS;
        near_angle = sweep_pos;
        target_held = 1'b1;
      end
      nxt = sweep_pos + eff_step();
      if (nxt <= eff_half()) begin
        sweep_pos = nxt;
        mv = steer_to(sweep_pos);
      end else if (target_held) begin
        locked = 1'b1;
        mv = steer_to(near_angle);
        last_evt = EV_FOUND;
      end else begin
        mv = restart_sweep();
        last_evt = EV_RESTART;
      end
    end
    r.move_steps   = mv[14:0];
    r.tracking     = locked;
    r.event_res    = last_evt;
    r.target_found = target_held;
    r.target_angle = target_held ? near_angle[8:0] : 9'd0;
    r.best_cm      = target_held ? near_cm[8:0] : 9'd0;
    expected_reports.push_back(r);
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_reports.size() == 0) begin
        $error("result transaction with nothing expected: %h", out_tdata);
        fail_count++;
      end else begin
        want_rpt = expected_reports.pop_front();
        check_field("move_steps", int'(want_rpt.move_steps), int'($signed(out_tdata[14:0])));
        check_field("tracking", int'(want_rpt.tracking), int'(out_tdata[15]));
        check_field("event_res", int'(want_rpt.event_res), int'(out_tdata[17:16]));
        check_field("target_found", int'(want_rpt.target_found), int'(out_tdata[18]));
        check_field("target_angle", int'(want_rpt.target_angle),
                    int'($signed(out_tdata[27:19])));
        check_field("best_cm", int'(want_rpt.best_cm), int'(out_tdata[36:28]));
      end
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet_stretch || ($urandom_range(99) >= 14);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // valid stays high between back-to-back items, lowered only for a gap
  task automatic offer_item(input logic kind, input logic [12:0] reading);
    if (!quiet_stretch && $urandom_range(99) < 14) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 14) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {3'b000, reading};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_motion(kind, int'(reading));
  endtask

  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MIN_VALID:  reg_min_valid = val[8:0];
      REG_SCAN_MAX:   reg_scan_max  = val[8:0];
      REG_LOST_MAX:   reg_lost_max  = val[8:0];
      REG_HALF_RANGE: reg_half      = val[7:0];
      REG_SWEEP_STEP: reg_step      = val[6:0];
      REG_STEPS_DEG:  reg_spd       = val[4:0];
      REG_CENTER:     reg_center    = val[11:0];
      default: ;
    endcase
  endtask

  task automatic apply_setup(input int mn, input int sc, input int lost, input int half,
                             input int step, input int spd, input int centre);
    settle_block();
    write_reg(REG_MIN_VALID, mn);
    write_reg(REG_SCAN_MAX, sc);
    write_reg(REG_LOST_MAX, lost);
    write_reg(REG_HALF_RANGE, half);
    write_reg(REG_SWEEP_STEP, step);
    write_reg(REG_STEPS_DEG, spd);
    write_reg(REG_CENTER, centre);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [12:0] span(input int a, input int b);
    int lo_v;
    int hi_v;
    lo_v = (a < 0) ? 0 : a;
    hi_v = (b > 8191) ? 8191 : b;
    if (lo_v > hi_v) return 13'($urandom);
    return 13'($urandom_range(hi_v, lo_v));
  endfunction

  // mostly in-window readings while tracking, a mix while sweeping
  function automatic logic [12:0] pick_distance();
    int lo;
    int hi;
    int r;
    lo = reg_min_valid << FRAC_BITS;
    r = $urandom_range(99);
    if (locked) begin
      hi = reg_lost_max << FRAC_BITS;
      if (r < 90) return span(lo, hi);
      if (r < 93) return span(0, lo - 1);
      if (r < 96) return span(hi + 1, 8191);
    end else begin
      hi = reg_scan_max << FRAC_BITS;
      if (r < hit_pct) return span(lo + 1, hi - 1);
      if (r < 85) return span(hi, 8191);
      if (r < 92) return span(0, lo);
    end
    if ($urandom_range(3) == 0) return ($urandom_range(1) != 0) ? 13'h1FFF : 13'h0000;
    return 13'($urandom);
  endfunction

  task automatic run_random_phase(input int count);
    logic        kind;
    logic [12:0] reading;
    for (int n = 0; n < count; n++) begin
      kind = (!sweeping || $urandom_range(99) < 3) ? KIND_START : KIND_READING;
      reading = (kind == KIND_START) ? 13'($urandom) : pick_distance();
      offer_item(kind, reading);
      if (last_evt != EV_NONE || kind == KIND_START) hit_pct = $urandom_range(60);
    end
  endtask

  // readings before any start are ignored
  task automatic test_idle_readings();
    offer_item(KIND_READING, 13'd0);
    offer_item(KIND_READING, 13'h1FFF);
  endtask

  task automatic test_sweep_and_track();
    apply_setup(2, 300, 400, 10, 10, 5, 1024);
    offer_item(KIND_START, 13'd0);
    offer_item(KIND_READING, 13'h1FFF);
    offer_item(KIND_READING, 13'd4800);     // exactly on scan limit, not counted
    offer_item(KIND_READING, 13'd40);       // target found at end of sweep
    offer_item(KIND_READING, 13'd32);       // tracking edges still hold
    offer_item(KIND_READING, 13'd6400);
    offer_item(KIND_READING, 13'd6401);     // target lost
    offer_item(KIND_READING, 13'd32);
    offer_item(KIND_READING, 13'd0);
    offer_item(KIND_READING, 13'h1FFF);     // empty sweep restarts
    offer_item(KIND_READING, 13'd4799);
    offer_item(KIND_READING, 13'd33);
    offer_item(KIND_READING, 13'd4000);
    offer_item(KIND_READING, 13'd31);       // below minimum while tracking
    offer_item(KIND_READING, 13'd100);
    offer_item(KIND_START, 13'h1FFF);       // restart mid sweep
    offer_item(KIND_READING, 13'd50);
    offer_item(KIND_READING, 13'd60);
    offer_item(KIND_READING, 13'd70);
    offer_item(KIND_READING, 13'd1000);
    offer_item(KIND_START, 13'd0);          // start while tracking
  endtask

  task automatic test_register_extremes();
    // zero half range and zero step: single-angle sweeps
    apply_setup(0, 511, 511, 0, 0, 16, 0);
    run_random_phase(120);
    // half range and steps per degree above their clamps
    apply_setup(511, 511, 511, 255, 127, 31, 4095);
    run_random_phase(120);
    apply_setup(0, 0, 0, 180, 90, 1, 2048);
    run_random_phase(60);
  endtask

  task automatic test_random_sweeps();
    apply_setup(MIN_VALID_RST, SCAN_MAX_RST, LOST_MAX_RST, HALF_RANGE_RST,
                SWEEP_STEP_RST, STEPS_DEG_RST, CENTER_RST);
    run_random_phase(250);
    apply_setup(20, 100, 150, 30, 7, 1, 2048);
    run_random_phase(200);
    apply_setup(5, 200, 250, 12, 3, 8, 500);
    run_random_phase(250);
    apply_setup(2, 300, 400, 20, 4, 16, 3000);
    quiet_stretch = 1'b1;
    run_random_phase(200);
    quiet_stretch = 1'b0;
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    apply_setup(2, 300, 400, 30, 5, 5, 1024);
    quiet_stretch = 1'b1;
    hold_requests++;
    run_random_phase(60);
    quiet_stretch = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_readings();
    test_sweep_and_track();
    test_register_extremes();
    test_random_sweeps();
    test_backpressure();
    settle_block();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/ssc_pkg.sv
hw/rtl/ssc_cfg_regs.sv
hw/rtl/ssc_core.sv
hw/rtl/sweep_scan_track_controller.sv
bench/sweep_scan_track_controller_tb.sv
